// File: design/tjpd_pkg.sv
// Shared types, constants and helpers of the two-joint PD torque controller.
package tjpd_pkg;

  localparam int Joints     = 2;
  localparam int JointIdxW  = (Joints > 1) ? $clog2(Joints) : 1;

  localparam int AngleW     = 24;
  localparam int PeriodW    = 16;
  localparam int TorqueW    = 16;
  localparam int RunW       = 32;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 20;
  localparam int TorqueLimit = 30720;

  // Velocity scale: 10^6 / 2^6 = 15625, the remaining 2^24 goes into a shift
  localparam int VelScale   = 15625;

  // Running value update r + floor((t - r + 500) / 1000)
  localparam int AppRound   = 500;
  localparam int AppDiv     = 1000;
  localparam int AppShift   = 43;
  localparam logic [33:0] AppRecip = 34'd8796093022;  // floor(2^43 / 1000)

  // Serial divider
  localparam int DivNumW    = 48;
  localparam int DivQBits   = 29;
  localparam int DivQuoW    = 31;
  localparam int DivCntW    = 5;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPropTarget  = 3'd0,
    CfgDerivTarget = 3'd1,
    CfgCoefTarget  = 3'd2,
    CfgPropStart   = 3'd3,
    CfgDerivStart  = 3'd4,
    CfgCoefStart   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [AngleW-1:0] angle_pan;
    logic signed [AngleW-1:0] angle_tilt;
    logic signed [AngleW-1:0] goal_pan;
    logic signed [AngleW-1:0] goal_tilt;
    logic        [PeriodW-1:0] period_us;
  } in_word_t;

  typedef struct packed {
    logic signed [TorqueW-1:0] torque_pan;
    logic signed [TorqueW-1:0] torque_tilt;
    logic                      clamp_pan;
    logic                      clamp_tilt;
  } out_word_t;

  typedef struct packed {
    logic                      start;
    logic signed [AngleW-1:0]  theta;
    logic signed [AngleW-1:0]  goal;
    logic        [PeriodW-1:0] period;
    logic        [RunW-1:0]    kp;
    logic        [RunW-1:0]    kd;
    logic        [RunW-1:0]    coef;
  } lane_cmd_t;

  typedef struct packed {
    logic                      done;
    logic signed [TorqueW-1:0] torque;
    logic                      clamp;
  } lane_res_t;

  typedef struct packed {
    logic                      start;
    logic signed [DivNumW-1:0] num;
    logic        [PeriodW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [DivQuoW-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic            go;
    logic [RunW-1:0] run;
    logic [RunW-1:0] target;
  } ap_req_t;

  typedef struct packed {
    logic            done;
    logic [RunW-1:0] run;
  } ap_rsp_t;

  // Q10.10 gain to Q10.22
  function automatic logic [RunW-1:0] gain_scale(input logic [19:0] g);
    return {g, 12'd0};
  endfunction

  // Q0.16 coefficient to Q0.32, one and above saturate
  function automatic logic [RunW-1:0] coef_scale(input logic [16:0] c);
    logic [RunW-1:0] r;
    if (c[16]) begin
      r = '1;
    end else begin
      r = {c[15:0], 16'd0};
    end
    return r;
  endfunction

endpackage

// File: design/two_joint_pd_torque_controller_unit.sv
// Top level: configuration, gain ramp sequencer, joint lanes and output register.
//
// One word carries both joints and gives one result word. After a word is
// accepted the running gains and filter coefficient step toward their
// targets once per joint through a four-stage update pipeline; then all
// joint lanes run side by side, each with the values seen by its joint, and
// their velocity term goes through a serial divider that makes one quotient
// bit a cycle in 29 steps, none when the velocity quotient saturates. No
// new word is taken while one is in flight; the input is free again as soon
// as the result sits in the output register. While a stalled result holds
// the output register, the next word's lanes keep their results and no
// further word is taken. Writing a start register reloads the matching
// running value, unless a ramp step result lands in the same cycle and wins.
module two_joint_pd_torque_controller_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  tjpd_pkg::in_word_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output tjpd_pkg::out_word_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [tjpd_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [tjpd_pkg::CfgDataW-1:0]       cfg_wdata_i
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StGain = 3'b010,
    StRun  = 3'b100
  } ctl_st_e;

  ctl_st_e state_q;
  logic [tjpd_pkg::JointIdxW-1:0] jcnt_q;
  logic ap_go_q, lane_start_q, out_valid_q;

  logic [19:0] tgt_kp_q, tgt_kd_q;
  logic [16:0] tgt_coef_q;
  logic [tjpd_pkg::RunW-1:0] run_kp_q, run_kd_q, run_coef_q;

  logic signed [tjpd_pkg::AngleW-1:0] theta_q [tjpd_pkg::Joints];
  logic signed [tjpd_pkg::AngleW-1:0] goal_q  [tjpd_pkg::Joints];
  logic [tjpd_pkg::PeriodW-1:0]       period_q;
  logic [tjpd_pkg::RunW-1:0] lane_kp_q   [tjpd_pkg::Joints];
  logic [tjpd_pkg::RunW-1:0] lane_kd_q   [tjpd_pkg::Joints];
  logic [tjpd_pkg::RunW-1:0] lane_coef_q [tjpd_pkg::Joints];
  tjpd_pkg::out_word_t out_data_q;

  tjpd_pkg::ap_req_t kp_req, kd_req, coef_req;
  tjpd_pkg::ap_rsp_t kp_rsp, kd_rsp, coef_rsp;
  tjpd_pkg::lane_cmd_t lane_cmd [tjpd_pkg::Joints];
  tjpd_pkg::lane_res_t lane_res [tjpd_pkg::Joints];

  logic in_take, out_free, all_done;

  assign in_stall_o = (state_q != StIdle);
  assign in_take    = in_valid_i && (state_q == StIdle);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    all_done = 1'b1;
    for (int g = 0; g < tjpd_pkg::Joints; g++) begin
      all_done = all_done & lane_res[g].done;
    end
  end

  assign kp_req   = '{go: ap_go_q, run: run_kp_q,
                      target: tjpd_pkg::gain_scale(tgt_kp_q)};
  assign kd_req   = '{go: ap_go_q, run: run_kd_q,
                      target: tjpd_pkg::gain_scale(tgt_kd_q)};
  assign coef_req = '{go: ap_go_q, run: run_coef_q,
                      target: tjpd_pkg::coef_scale(tgt_coef_q)};

  tjpd_approach u_ap_kp (
    .clk_i (clk_i), .rst_ni (rst_ni), .req_i (kp_req), .rsp_o (kp_rsp)
  );
  tjpd_approach u_ap_kd (
    .clk_i (clk_i), .rst_ni (rst_ni), .req_i (kd_req), .rsp_o (kd_rsp)
  );
  tjpd_approach u_ap_coef (
    .clk_i (clk_i), .rst_ni (rst_ni), .req_i (coef_req), .rsp_o (coef_rsp)
  );

  for (genvar g = 0; g < tjpd_pkg::Joints; g++) begin : g_lane
    assign lane_cmd[g] = '{start:  lane_start_q,
                           theta:  theta_q[g],
                           goal:   goal_q[g],
                           period: period_q,
                           kp:     lane_kp_q[g],
                           kd:     lane_kd_q[g],
                           coef:   lane_coef_q[g]};
    tjpd_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (lane_cmd[g]),
      .res_o  (lane_res[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      jcnt_q       <= '0;
      ap_go_q      <= 1'b0;
      lane_start_q <= 1'b0;
      out_valid_q  <= 1'b0;
      tgt_kp_q     <= '0;
      tgt_kd_q     <= '0;
      tgt_coef_q   <= '0;
      run_kp_q     <= '0;
      run_kd_q     <= '0;
      run_coef_q   <= '0;
    end else begin
      ap_go_q      <= 1'b0;
      lane_start_q <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tjpd_pkg::CfgPropTarget:  tgt_kp_q   <= cfg_wdata_i[19:0];
          tjpd_pkg::CfgDerivTarget: tgt_kd_q   <= cfg_wdata_i[19:0];
          tjpd_pkg::CfgCoefTarget:  tgt_coef_q <= cfg_wdata_i[16:0];
          tjpd_pkg::CfgPropStart:   run_kp_q   <= tjpd_pkg::gain_scale(cfg_wdata_i[19:0]);
          tjpd_pkg::CfgDerivStart:  run_kd_q   <= tjpd_pkg::gain_scale(cfg_wdata_i[19:0]);
          tjpd_pkg::CfgCoefStart:   run_coef_q <= tjpd_pkg::coef_scale(cfg_wdata_i[16:0]);
          default: ;
        endcase
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            state_q <= StGain;
            jcnt_q  <= '0;
            ap_go_q <= 1'b1;
          end
        end
        StGain: begin
          if (kp_rsp.done) begin
            run_kp_q   <= kp_rsp.run;
            run_kd_q   <= kd_rsp.run;
            run_coef_q <= coef_rsp.run;
            if (jcnt_q == tjpd_pkg::JointIdxW'(tjpd_pkg::Joints - 1)) begin
              state_q      <= StRun;
              lane_start_q <= 1'b1;
            end else begin
              jcnt_q  <= jcnt_q + 1'b1;
              ap_go_q <= 1'b1;
            end
          end
        end
        StRun: begin
          // lane done flags are stale while the start pulse is out
          if (!lane_start_q && all_done && out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      theta_q[0] <= in_data_i.angle_pan;
      theta_q[1] <= in_data_i.angle_tilt;
      goal_q[0]  <= in_data_i.goal_pan;
      goal_q[1]  <= in_data_i.goal_tilt;
      period_q   <= (in_data_i.period_us == '0) ? tjpd_pkg::PeriodW'(1)
                                                : in_data_i.period_us;
    end
    // snapshot the values this joint sees before the ramp step
    if (ap_go_q) begin
      lane_kp_q[jcnt_q]   <= run_kp_q;
      lane_kd_q[jcnt_q]   <= run_kd_q;
      lane_coef_q[jcnt_q] <= run_coef_q;
    end
    if (state_q == StRun && !lane_start_q && all_done && out_free) begin
      out_data_q.torque_pan  <= lane_res[0].torque;
      out_data_q.torque_tilt <= lane_res[1].torque;
      out_data_q.clamp_pan   <= lane_res[0].clamp;
      out_data_q.clamp_tilt  <= lane_res[1].clamp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: design/tjpd_approach.sv
// Four-stage pipeline that moves a running value 0.001 of the way to its target.
module tjpd_approach (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tjpd_pkg::ap_req_t  req_i,
  output tjpd_pkg::ap_rsp_t  rsp_o
);

  logic                  v1_q, v2_q, v3_q, v4_q;
  logic                  neg1_q, neg2_q, neg3_q;
  logic [32:0]           mag1_q, mag2_q;
  logic [31:0]           run1_q, run2_q, run3_q, run4_q;
  logic [66:0]           prod_q;
  logic [23:0]           quo3_q;

  logic signed [33:0]    x_d;
  logic signed [33:0]    negmag_d;
  logic [32:0]           mag_d;
  logic [23:0]           q0;
  logic [33:0]           rem;
  logic [23:0]           quo_d;
  logic signed [32:0]    delta;
  logic signed [32:0]    run_new;

  always_comb begin
    x_d      = $signed({2'b00, req_i.target}) - $signed({2'b00, req_i.run})
             + 34'(tjpd_pkg::AppRound);
    // floor of a negative quotient: ceil of the magnitude
    negmag_d = -x_d + 34'(tjpd_pkg::AppDiv - 1);
    mag_d    = x_d[33] ? negmag_d[32:0] : x_d[32:0];
  end

  always_comb begin
    q0    = prod_q[tjpd_pkg::AppShift +: 24];
    rem   = {1'b0, mag2_q} - (34'(q0) * 34'(tjpd_pkg::AppDiv));
    quo_d = (rem >= 34'(tjpd_pkg::AppDiv)) ? q0 + 24'd1 : q0;
  end

  always_comb begin
    delta   = neg3_q ? -$signed({9'd0, quo3_q}) : $signed({9'd0, quo3_q});
    run_new = $signed({1'b0, run3_q}) + delta;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= req_i.go;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    neg1_q <= x_d[33];
    mag1_q <= mag_d;
    run1_q <= req_i.run;

    prod_q <= 67'(mag1_q) * 67'(tjpd_pkg::AppRecip);
    mag2_q <= mag1_q;
    neg2_q <= neg1_q;
    run2_q <= run1_q;

    quo3_q <= quo_d;
    neg3_q <= neg2_q;
    run3_q <= run2_q;

    run4_q <= run_new[31:0];
  end

  assign rsp_o.done = v4_q;
  assign rsp_o.run  = run4_q;

endmodule

// File: design/tjpd_divider.sv
// Restoring divider, one quotient bit a cycle, floor quotient saturated to +-2^29.
module tjpd_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tjpd_pkg::div_req_t req_i,
  output tjpd_pkg::div_rsp_t rsp_o
);

  logic                                busy_q, done_q, neg_q;
  logic [tjpd_pkg::DivCntW-1:0]        cnt_q;
  logic [tjpd_pkg::PeriodW-1:0]        den_q, rem_q;
  logic [tjpd_pkg::DivQBits-1:0]       sh_q;
  logic signed [tjpd_pkg::DivQuoW-1:0] quo_q;

  logic [tjpd_pkg::DivNumW-1:0]        mag_full;
  logic [tjpd_pkg::DivNumW-2:0]        mag;
  logic                                ovf;
  logic [tjpd_pkg::PeriodW:0]          trial, trial_sub;
  logic                                ge;
  logic [tjpd_pkg::DivQBits-1:0]       quot_next;
  logic signed [tjpd_pkg::DivQuoW-1:0] quo_pos, quo_sat;

  always_comb begin
    // -num + den - 1 == ~num + den
    mag_full = req_i.num[tjpd_pkg::DivNumW-1]
             ? (~req_i.num + {32'd0, req_i.den})
             : req_i.num;
    mag      = mag_full[tjpd_pkg::DivNumW-2:0];
    ovf      = mag >= {2'b00, req_i.den, 29'd0};
    quo_sat  = req_i.num[tjpd_pkg::DivNumW-1] ? {2'b11, 29'd0} : {2'b01, 29'd0};
  end

  always_comb begin
    trial     = {rem_q, sh_q[tjpd_pkg::DivQBits-1]};
    trial_sub = trial - {1'b0, den_q};
    ge        = trial >= {1'b0, den_q};
    quot_next = {sh_q[tjpd_pkg::DivQBits-2:0], ge};
    quo_pos   = $signed({2'b00, quot_next});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= !ovf;
        done_q <= ovf;
      end else if (busy_q && cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.num[tjpd_pkg::DivNumW-1];
      den_q <= req_i.den;
      // quotient fits 29 bits here, so the upper part is below the divisor
      rem_q <= mag[44:29];
      sh_q  <= mag[tjpd_pkg::DivQBits-1:0];
      cnt_q <= tjpd_pkg::DivCntW'(tjpd_pkg::DivQBits - 1);
      quo_q <= quo_sat;
    end else if (busy_q) begin
      rem_q <= ge ? trial_sub[tjpd_pkg::PeriodW-1:0] : trial[tjpd_pkg::PeriodW-1:0];
      sh_q  <= quot_next;
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        quo_q <= neg_q ? -quo_pos : quo_pos;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// File: design/tjpd_lane.sv
// One joint: setpoint filter, PD terms, velocity division and torque clamp.
module tjpd_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tjpd_pkg::lane_cmd_t cmd_i,
  output tjpd_pkg::lane_res_t res_o
);

  typedef enum logic [5:0] {
    LIdle  = 6'b000001,
    LFilt  = 6'b000010,
    LUpd   = 6'b000100,
    LMul   = 6'b001000,
    LDivGo = 6'b010000,
    LDiv   = 6'b100000
  } lane_st_e;

  lane_st_e state_q;
  logic     done_q;

  logic signed [23:0]  sp_q, prev_q;
  logic signed [57:0]  fprod_q, vprod_q;
  logic signed [27:0]  pterm_q;
  logic signed [47:0]  num_q;
  logic signed [15:0]  torque_q;
  logic                clamp_q;

  logic signed [32:0]  coef_s, kp_s, kd_s;
  logic signed [24:0]  fdiff, dang, err;
  logic signed [57:0]  fprod_d, vprod_d, pprod_d, fsum;
  logic signed [72:0]  nprod_d;
  logic signed [25:0]  step, sp_new;
  logic signed [31:0]  tsum;
  logic signed [30:0]  tq, tq_max, tq_min;

  tjpd_pkg::div_req_t  div_req;
  tjpd_pkg::div_rsp_t  div_rsp;

  always_comb begin
    coef_s  = $signed({1'b0, cmd_i.coef});
    kp_s    = $signed({1'b0, cmd_i.kp});
    kd_s    = $signed({1'b0, cmd_i.kd});
    fdiff   = $signed({cmd_i.goal[23], cmd_i.goal}) - $signed({sp_q[23], sp_q});
    fprod_d = fdiff * coef_s;
    // round to nearest, ties up
    fsum    = fprod_q + $signed({26'd0, 1'b1, 31'd0});
    step    = $signed(fsum[57:32]);
    sp_new  = $signed({{2{sp_q[23]}}, sp_q}) + step;
    dang    = $signed({cmd_i.theta[23], cmd_i.theta}) - $signed({prev_q[23], prev_q});
    vprod_d = dang * kd_s;
    err     = $signed({sp_q[23], sp_q}) - $signed({cmd_i.theta[23], cmd_i.theta});
    pprod_d = err * kp_s;
    nprod_d = vprod_q * $signed(15'(tjpd_pkg::VelScale));
  end

  always_comb begin
    tq_max = 31'(tjpd_pkg::TorqueLimit);
    tq_min = -tq_max;
    tsum   = $signed({{4{pterm_q[27]}}, pterm_q}) - $signed({div_rsp.quo[30], div_rsp.quo})
           + 32'sd1;
    tq     = $signed(tsum[31:1]);
  end

  assign div_req.start = (state_q == LDivGo);
  assign div_req.num   = num_q;
  assign div_req.den   = cmd_i.period;

  tjpd_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LIdle;
      done_q  <= 1'b0;
      sp_q    <= '0;
      prev_q  <= '0;
    end else begin
      case (state_q)
        LIdle: begin
          if (cmd_i.start) begin
            state_q <= LFilt;
            done_q  <= 1'b0;
          end
        end
        LFilt:  state_q <= LUpd;
        LUpd: begin
          sp_q    <= sp_new[23:0];
          prev_q  <= cmd_i.theta;
          state_q <= LMul;
        end
        LMul:   state_q <= LDivGo;
        LDivGo: state_q <= LDiv;
        LDiv: begin
          if (div_rsp.done) begin
            done_q  <= 1'b1;
            state_q <= LIdle;
          end
        end
        default: state_q <= LIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      LFilt: fprod_q <= fprod_d;
      LUpd:  vprod_q <= vprod_d;
      LMul: begin
        pterm_q <= pprod_d[57:30];
        num_q   <= nprod_d[71:24];
      end
      LDiv: begin
        if (div_rsp.done) begin
          if (tq > tq_max) begin
            torque_q <= tq_max[15:0];
            clamp_q  <= 1'b1;
          end else if (tq < tq_min) begin
            torque_q <= tq_min[15:0];
            clamp_q  <= 1'b1;
          end else begin
            torque_q <= tq[15:0];
            clamp_q  <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  assign res_o.done   = done_q;
  assign res_o.torque = torque_q;
  assign res_o.clamp  = clamp_q;

endmodule
